// ===== hdl/mdw_pkg.sv =====
// shared types, codes and wall helpers for the grid maze walker
`default_nettype none

package mdw_pkg;

  localparam int DEF_MAX_SIDE   = 32;
  localparam int DEF_CELL_LIMIT = 1024;

  typedef enum logic [1:0] {
    REQ_START     = 2'd0,
    REQ_STEP      = 2'd1,
    REQ_READ_WALL = 2'd2,
    REQ_READ_PATH = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_RUN_MODE    = 3'd2,
    CFG_START_X     = 3'd3,
    CFG_START_Y     = 3'd4,
    CFG_END_X       = 3'd5,
    CFG_END_Y       = 3'd6
  } cfg_reg_t;

  localparam logic [3:0] WALL_LEFT  = 4'b0001;
  localparam logic [3:0] WALL_RIGHT = 4'b0010;
  localparam logic [3:0] WALL_UP    = 4'b0100;
  localparam logic [3:0] WALL_DOWN  = 4'b1000;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] direction;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [9:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic        advanced;
    logic        backtracked;
    logic        finished;
    logic        failed;
    logic        wall_left;
    logic        wall_right;
    logic        wall_up;
    logic        wall_down;
    logic [10:0] depth;
  } out_item_t;

  // wall crossed when leaving a cell in direction d
  function automatic logic [3:0] dir_wall(input logic [1:0] d);
    logic [3:0] w;
    case (d)
      DIR_DOWN:  w = WALL_DOWN;
      DIR_UP:    w = WALL_UP;
      DIR_RIGHT: w = WALL_RIGHT;
      default:   w = WALL_LEFT;
    endcase
    return w;
  endfunction

  // matching wall on the neighbouring cell
  function automatic logic [3:0] dir_back(input logic [1:0] d);
    logic [3:0] w;
    case (d)
      DIR_DOWN:  w = WALL_UP;
      DIR_UP:    w = WALL_DOWN;
      DIR_RIGHT: w = WALL_LEFT;
      default:   w = WALL_RIGHT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/grid_maze_dfs_walker.sv =====
// top level of the depth-first maze walker: sequencer, registers and memories
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+----------------------
//  cfg     | cfg_valid cfg_ready cfg_index/data| in        | cfg_valid && cfg_ready
//  in      | in_valid in_stall in_data         | in        | in_valid && !in_stall
//  out     | out_valid out_stall out_data      | out       | out_valid && !out_stall
//
// path of a step: straight to S_RESP when finished, on an empty stack or after a pop
// that empties it; else S_POPRD after a pop to reread the stack top, then S_TRY, which
// answers on a blocked direction and goes to S_FIN for a neighbour off the grid,
// else S_EVAL for the visited/wall probe, then S_CARVE for the second wall write when
// carving, and S_FIN; a read goes through S_WRD or S_PRD unless out of range; a start
// sweeps the visited memory clear (and sets all walls in generate mode) before S_INIT
// reset: a sweep sets every wall and clears every visited bit; in_stall is high
// during it, configuration writes are taken throughout
// stalls: one item is in work at a time; a finished result sits in the output
// register so the next item can be taken while it waits
`default_nettype none

module grid_maze_dfs_walker #(
  parameter int MAX_SIDE   = mdw_pkg::DEF_MAX_SIDE,
  parameter int CELL_LIMIT = mdw_pkg::DEF_CELL_LIMIT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [5:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mdw_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mdw_pkg::out_item_t     out_data
);

  import mdw_pkg::*;

  // widths derived from the grid limits
  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW    = $clog2(CELL_LIMIT);
  localparam int NW    = CW + 1;
  localparam int CMPW  = (XW > 5) ? XW : 5;
  localparam int KW    = CMPW + 1;
  localparam int AW    = 2 * KW;
  localparam int SW    = 2 * XW;
  localparam int TW    = (NW > 12) ? NW : 12;
  localparam int WCAP  = (MAX_SIDE < CELL_LIMIT) ? MAX_SIDE : CELL_LIMIT;
  localparam int HCAP0 = CELL_LIMIT / MAX_SIDE;
  localparam int HCAP  = (HCAP0 < 1) ? 1 : ((HCAP0 > MAX_SIDE) ? MAX_SIDE : HCAP0);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_INIT  = 11'b00000000100,
    S_POPRD = 11'b00000001000,
    S_TRY   = 11'b00000010000,
    S_EVAL  = 11'b00000100000,
    S_CARVE = 11'b00001000000,
    S_FIN   = 11'b00010000000,
    S_WRD   = 11'b00100000000,
    S_PRD   = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [5:0] grid_width, grid_height;
  logic       run_mode;
  logic [4:0] start_x, start_y, end_x, end_y;

  // walk state
  logic [NW-1:0] count;
  logic [3:0]    blocked;
  logic [NW-1:0] visited_total;
  logic          done;
  logic [XW-1:0] top_x, top_y;
  logic [XW-1:0] nb_x, nb_y;
  logic [CW-1:0] nb_c;

  // sweep control
  logic [NW-1:0] clr_cnt;
  logic          clr_walls;
  logic          clr_init;

  // request and result bookkeeping
  in_item_t   rq;
  logic       adv, back;
  logic [3:0] resp_walls;
  logic [4:0] path_x, path_y;

  // memory ports
  logic [CW-1:0] wall_raddr, wall_waddr, vis_raddr, vis_waddr;
  logic [3:0]    wall_rdata, wall_wdata;
  logic          wall_we, vis_rdata, vis_we, vis_wdata;
  logic [CW-1:0] stk_raddr, stk_waddr;
  logic [SW-1:0] stk_rdata, stk_wdata;
  logic          stk_we;

  // effective grid size after clamping
  logic [5:0]  eff_w, eff_h;
  logic [11:0] total_cells;

  assign eff_w = (grid_width == 6'd0) ? 6'd1 :
                 ((32'(grid_width) > WCAP) ? 6'(WCAP) : grid_width);
  assign eff_h = (grid_height == 6'd0) ? 6'd1 :
                 ((32'(grid_height) > HCAP) ? 6'(HCAP) : grid_height);
  assign total_cells = 12'(eff_w) * 12'(eff_h);

  function automatic logic [AW-1:0] cell_sum(input logic [KW-1:0] x, input logic [KW-1:0] y);
    return AW'(y) * AW'(MAX_SIDE) + AW'(x);
  endfunction

  function automatic logic in_grid(input logic [KW-1:0] x, input logic [KW-1:0] y,
                                   input logic [5:0] ew, input logic [5:0] eh);
    return (x < KW'(ew)) && (y < KW'(eh)) && (32'(cell_sum(x, y)) < CELL_LIMIT);
  endfunction

  // cell numbers used in several states
  logic [AW-1:0] top_sum, rd_sum, st_sum;
  logic          rd_ok, st_ok;

  assign top_sum = cell_sum(KW'(top_x), KW'(top_y));
  assign rd_sum  = cell_sum(KW'(in_data.cell_x), KW'(in_data.cell_y));
  assign st_sum  = cell_sum(KW'(start_x), KW'(start_y));
  assign rd_ok   = in_grid(KW'(in_data.cell_x), KW'(in_data.cell_y), eff_w, eff_h);
  assign st_ok   = in_grid(KW'(start_x), KW'(start_y), eff_w, eff_h);

  // neighbour of the stack top in the requested direction
  logic [KW-1:0] try_x, try_y;
  logic          try_bad, try_ok;
  logic [AW-1:0] try_sum;

  always_comb begin
    try_x   = KW'(top_x);
    try_y   = KW'(top_y);
    try_bad = 1'b0;
    case (rq.direction)
      DIR_DOWN: begin
        if (top_y == '0) try_bad = 1'b1;
        else try_y = KW'(top_y) - KW'(1);
      end
      DIR_UP:    try_y = KW'(top_y) + KW'(1);
      DIR_RIGHT: try_x = KW'(top_x) + KW'(1);
      default: begin
        if (top_x == '0) try_bad = 1'b1;
        else try_x = KW'(top_x) - KW'(1);
      end
    endcase
    try_ok  = !try_bad && in_grid(try_x, try_y, eff_w, eff_h);
    try_sum = cell_sum(try_x, try_y);
  end

  // probe result: neighbour free and, when solving, the wall open
  logic eval_ok;
  assign eval_ok = !vis_rdata && !(run_mode && ((wall_rdata & dir_wall(rq.direction)) != 4'd0));

  logic       path_in_range;
  logic       top_is_end;
  assign path_in_range = (32'(in_data.entry_index) < 32'(count)) &&
                         (32'(in_data.entry_index) < CELL_LIMIT);
  assign top_is_end = (CMPW'(top_x) == CMPW'(end_x)) && (CMPW'(top_y) == CMPW'(end_y));

  // memory control
  always_comb begin
    wall_raddr = top_sum[CW-1:0];
    wall_we    = 1'b0;
    wall_waddr = top_sum[CW-1:0];
    wall_wdata = wall_rdata;
    vis_raddr  = nb_c;
    vis_we     = 1'b0;
    vis_waddr  = nb_c;
    vis_wdata  = 1'b1;
    stk_raddr  = CW'(count - NW'(2));
    stk_we     = 1'b0;
    stk_waddr  = count[CW-1:0];
    stk_wdata  = {nb_y, nb_x};
    case (state)
      S_IDLE: begin
        wall_raddr = rd_sum[CW-1:0];
        if (in_data.req_type == REQ_READ_PATH) stk_raddr = CW'(in_data.entry_index);
      end
      S_CLEAR: begin
        // sweep: visited cleared, walls set on reset and for a new maze
        vis_we     = 1'b1;
        vis_waddr  = clr_cnt[CW-1:0];
        vis_wdata  = 1'b0;
        wall_we    = clr_walls;
        wall_waddr = clr_cnt[CW-1:0];
        wall_wdata = 4'hf;
      end
      S_INIT: begin
        if (!run_mode) begin
          vis_we    = 1'b1;
          vis_waddr = '0;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '0;
        end else if (st_ok) begin
          vis_we    = 1'b1;
          vis_waddr = st_sum[CW-1:0];
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {XW'(start_y), XW'(start_x)};
        end
      end
      S_TRY: begin
        vis_raddr  = try_sum[CW-1:0];
        wall_raddr = top_sum[CW-1:0];
      end
      S_EVAL: begin
        if (eval_ok) begin
          vis_we = 1'b1;
          stk_we = (32'(count) < CELL_LIMIT);
          if (!run_mode) begin
            // knock down the wall on this side, fetch the neighbour's walls
            wall_we    = 1'b1;
            wall_waddr = top_sum[CW-1:0];
            wall_wdata = wall_rdata & ~dir_wall(rq.direction);
            wall_raddr = nb_c;
          end
        end
      end
      S_CARVE: begin
        wall_we    = 1'b1;
        wall_waddr = nb_c;
        wall_wdata = wall_rdata & ~dir_back(rq.direction);
      end
      default: ;
    endcase
  end

  mdw_cell_mem #(
    .CELLS (CELL_LIMIT),
    .CW    (CW)
  ) u_cell_mem (
    .clk        (clk),
    .wall_raddr (wall_raddr),
    .wall_rdata (wall_rdata),
    .wall_we    (wall_we),
    .wall_waddr (wall_waddr),
    .wall_wdata (wall_wdata),
    .vis_raddr  (vis_raddr),
    .vis_rdata  (vis_rdata),
    .vis_we     (vis_we),
    .vis_waddr  (vis_waddr),
    .vis_wdata  (vis_wdata)
  );

  mdw_stack_mem #(
    .DEPTH (CELL_LIMIT),
    .AW    (CW),
    .DW    (SW)
  ) u_stack_mem (
    .clk   (clk),
    .raddr (stk_raddr),
    .rdata (stk_rdata),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 6'd32;
      grid_height <= 6'd32;
      run_mode    <= 1'b0;
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= '0;
      end_y       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_RUN_MODE:    run_mode    <= cfg_data[0];
        CFG_START_X:     start_x     <= cfg_data[4:0];
        CFG_START_Y:     start_y     <= cfg_data[4:0];
        CFG_END_X:       end_x       <= cfg_data[4:0];
        CFG_END_Y:       end_y       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // result assembled from the walk state
  out_item_t resp;
  always_comb begin
    resp             = '0;
    resp.advanced    = adv;
    resp.backtracked = back;
    resp.finished    = done;
    resp.failed      = (count == '0) && !done;
    resp.depth       = 11'(count);
    if (rq.req_type == REQ_READ_PATH) begin
      resp.pos_x = path_x;
      resp.pos_y = path_y;
    end else if (count != '0) begin
      resp.pos_x = 5'(top_x);
      resp.pos_y = 5'(top_y);
    end
    if (rq.req_type == REQ_READ_WALL) begin
      resp.wall_left  = resp_walls[0];
      resp.wall_right = resp_walls[1];
      resp.wall_up    = resp_walls[2];
      resp.wall_down  = resp_walls[3];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      clr_walls     <= 1'b1;
      clr_init      <= 1'b0;
      count         <= '0;
      blocked       <= '0;
      visited_total <= '0;
      done          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // output register loads from S_RESP once its previous transfer is gone
      if (state == S_RESP && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq         <= in_data;
            adv        <= 1'b0;
            back       <= 1'b0;
            resp_walls <= '0;
            path_x     <= '0;
            path_y     <= '0;
            case (in_data.req_type)
              REQ_START: begin
                count     <= '0;
                blocked   <= '0;
                done      <= 1'b0;
                clr_cnt   <= '0;
                clr_walls <= !run_mode;
                clr_init  <= 1'b1;
                state     <= S_CLEAR;
              end
              REQ_STEP: begin
                if (done || count == '0) begin
                  state <= S_RESP;
                end else if (blocked == 4'hf) begin
                  // dead end: pop, then reread the new top unless the stack is now empty
                  count   <= count - NW'(1);
                  blocked <= '0;
                  back    <= 1'b1;
                  state   <= (count == NW'(1)) ? S_RESP : S_POPRD;
                end else begin
                  state <= S_TRY;
                end
              end
              REQ_READ_WALL: state <= rd_ok ? S_WRD : S_RESP;
              default:       state <= path_in_range ? S_PRD : S_RESP;
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (32'(clr_cnt) == CELL_LIMIT - 1) begin
            state <= clr_init ? S_INIT : S_IDLE;
          end
        end
        S_INIT: begin
          if (!run_mode) begin
            count         <= NW'(1);
            top_x         <= '0;
            top_y         <= '0;
            visited_total <= NW'(1);
            done          <= (total_cells == 12'd1);
          end else if (st_ok) begin
            count         <= NW'(1);
            top_x         <= XW'(start_x);
            top_y         <= XW'(start_y);
            visited_total <= NW'(1);
            done          <= (start_x == end_x) && (start_y == end_y);
          end else begin
            visited_total <= '0;
          end
          state <= S_RESP;
        end
        S_POPRD: begin
          top_y <= stk_rdata[SW-1:XW];
          top_x <= stk_rdata[XW-1:0];
          state <= S_TRY;
        end
        S_TRY: begin
          if (blocked[rq.direction]) begin
            state <= S_RESP;
          end else if (!try_ok) begin
            blocked[rq.direction] <= 1'b1;
            state                 <= S_FIN;
          end else begin
            nb_x  <= XW'(try_x);
            nb_y  <= XW'(try_y);
            nb_c  <= try_sum[CW-1:0];
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!eval_ok) begin
            blocked[rq.direction] <= 1'b1;
            state                 <= S_FIN;
          end else begin
            if (32'(count) < CELL_LIMIT) begin
              count <= count + NW'(1);
              top_x <= nb_x;
              top_y <= nb_y;
            end
            blocked       <= '0;
            visited_total <= visited_total + NW'(1);
            adv           <= 1'b1;
            if (!run_mode && TW'(visited_total + NW'(1)) == TW'(total_cells)) done <= 1'b1;
            state <= run_mode ? S_FIN : S_CARVE;
          end
        end
        S_CARVE: state <= S_FIN;
        S_FIN: begin
          // solving ends once the top of the path is the goal
          if (run_mode && count != '0 && top_is_end) done <= 1'b1;
          state <= S_RESP;
        end
        S_WRD: begin
          resp_walls <= wall_rdata;
          state      <= S_RESP;
        end
        S_PRD: begin
          path_x <= 5'(stk_rdata[XW-1:0]);
          path_y <= 5'(stk_rdata[SW-1:XW]);
          state  <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_data <= resp;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mdw_cell_mem.sv =====
// per-cell wall and visited memories, one read and one write port each
`default_nettype none

module mdw_cell_mem #(
  parameter int CELLS = 1024,
  parameter int CW    = 10
) (
  input  wire logic          clk,
  input  wire logic [CW-1:0] wall_raddr,
  output logic      [3:0]    wall_rdata,
  input  wire logic          wall_we,
  input  wire logic [CW-1:0] wall_waddr,
  input  wire logic [3:0]    wall_wdata,
  input  wire logic [CW-1:0] vis_raddr,
  output logic               vis_rdata,
  input  wire logic          vis_we,
  input  wire logic [CW-1:0] vis_waddr,
  input  wire logic          vis_wdata
);

  logic [3:0] wall_ram [CELLS];
  logic       vis_ram  [CELLS];

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_ram[wall_waddr] <= wall_wdata;
    end
    wall_rdata <= wall_ram[wall_raddr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_ram[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_ram[vis_raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/mdw_stack_mem.sv =====
// path stack memory holding packed cell coordinates
`default_nettype none

module mdw_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);

  logic [DW-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    rdata <= ram[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/sv/grid_maze_dfs_walker_tb.sv =====
// self-checking testbench for the depth-first grid maze walker
`default_nettype none

module grid_maze_dfs_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdw_pkg::*;

  localparam int SIDE  = 32;
  localparam int CELLS = 1024;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  grid_maze_dfs_walker dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the walker: configuration registers
  logic [5:0] grid_w_reg, grid_h_reg;
  logic       mode_reg;
  logic [4:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;

  // shadow of the walker: maze memories and walk state
  logic [3:0]  maze_walls [CELLS];
  logic        maze_seen  [CELLS];
  logic [9:0]  path_stack [CELLS];
  logic [10:0] path_depth;
  logic [3:0]  blocked_mask;
  logic [10:0] seen_total;
  logic        run_done;

  out_item_t expected_out_q[$];
  int        errors = 0;
  int        items_sent = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        recv_hold_cycles = 0;

  // effective grid size, out-of-range sizes clamp to 1..SIDE
  function automatic int eff_cols();
    int w;
    w = grid_w_reg;
    if (w < 1) w = 1;
    if (w > SIDE) w = SIDE;
    return w;
  endfunction

  function automatic int eff_rows();
    int h;
    h = grid_h_reg;
    if (h < 1) h = 1;
    if (h > CELLS / SIDE) h = CELLS / SIDE;
    return h;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x < eff_cols() && y < eff_rows();
  endfunction

  // wall bit crossed leaving a cell, and the opposite bit on the neighbour
  function automatic logic [3:0] exit_wall(dir_t d);
    case (d)
      DIR_DOWN:  return WALL_DOWN;
      DIR_UP:    return WALL_UP;
      DIR_RIGHT: return WALL_RIGHT;
      default:   return WALL_LEFT;
    endcase
  endfunction

  function automatic logic [3:0] entry_wall(dir_t d);
    case (d)
      DIR_DOWN:  return WALL_UP;
      DIR_UP:    return WALL_DOWN;
      DIR_RIGHT: return WALL_LEFT;
      default:   return WALL_RIGHT;
    endcase
  endfunction

  function automatic void reset_maze();
    for (int i = 0; i < CELLS; i++) begin
      maze_walls[i] = 4'hF;
      maze_seen[i]  = 1'b0;
      path_stack[i] = '0;
    end
    path_depth = '0;
    blocked_mask = '0;
    seen_total = '0;
    run_done = 1'b0;
  endfunction

  function automatic void push_cell(int c);
    if (path_depth < CELLS) begin
      path_stack[path_depth] = c[9:0];
      path_depth++;
    end
  endfunction

  function automatic void open_run();
    int c;
    for (int i = 0; i < CELLS; i++) maze_seen[i] = 1'b0;
    path_depth = '0;
    blocked_mask = '0;
    run_done = 1'b0;
    if (mode_reg == 1'b0) begin
      for (int i = 0; i < CELLS; i++) maze_walls[i] = 4'hF;
      maze_seen[0] = 1'b1;
      push_cell(0);
      seen_total = 11'd1;
      if (eff_cols() * eff_rows() == 1) run_done = 1'b1;
    end else begin
      seen_total = '0;
      if (on_grid(start_x_reg, start_y_reg)) begin
        c = start_y_reg * SIDE + start_x_reg;
        maze_seen[c] = 1'b1;
        push_cell(c);
        seen_total = 11'd1;
        if (start_x_reg == goal_x_reg && start_y_reg == goal_y_reg) run_done = 1'b1;
      end
    end
  endfunction

  // one walk step; returns {advanced, backtracked}
  function automatic logic [1:0] walk_step(dir_t d);
    int c, x, y, nx, ny, nc, t;
    bit ok, adv, back;
    adv = 0;
    back = 0;
    if (run_done || path_depth == 0) return 2'b00;
    if (blocked_mask == 4'hF) begin
      path_depth--;
      blocked_mask = '0;
      back = 1;
      if (path_depth == 0) return {1'b0, back};
    end
    if (blocked_mask[d]) return {1'b0, back};
    c = path_stack[path_depth - 1];
    x = c % SIDE;
    y = c / SIDE;
    nx = x;
    ny = y;
    ok = 1;
    case (d)
      DIR_DOWN:  if (y == 0) ok = 0; else ny = y - 1;
      DIR_UP:    ny = y + 1;
      DIR_RIGHT: nx = x + 1;
      default:   if (x == 0) ok = 0; else nx = x - 1;
    endcase
    if (ok && !on_grid(nx, ny)) ok = 0;
    nc = ok ? ny * SIDE + nx : 0;
    if (ok && maze_seen[nc]) ok = 0;
    if (ok && mode_reg && (maze_walls[c] & exit_wall(d)) != 0) ok = 0;
    if (!ok) begin
      blocked_mask[d] = 1'b1;
    end else begin
      // carving knocks down the wall on both sides
      if (!mode_reg) begin
        maze_walls[c]  = maze_walls[c] & ~exit_wall(d);
        maze_walls[nc] = maze_walls[nc] & ~entry_wall(d);
      end
      maze_seen[nc] = 1'b1;
      push_cell(nc);
      blocked_mask = '0;
      seen_total++;
      adv = 1;
      if (!mode_reg && seen_total == eff_cols() * eff_rows()) run_done = 1'b1;
    end
    if (mode_reg && path_depth > 0) begin
      t = path_stack[path_depth - 1];
      if (t % SIDE == goal_x_reg && t / SIDE == goal_y_reg) run_done = 1'b1;
    end
    return {adv, back};
  endfunction

  // expected result of one request
  function automatic out_item_t predict_walk(in_item_t it);
    out_item_t r;
    logic [1:0] flags;
    logic [3:0] w;
    int e;
    r = '0;
    flags = 2'b00;
    case (req_kind_t'(it.req_type))
      REQ_START: open_run();
      REQ_STEP:  flags = walk_step(dir_t'(it.direction));
      default: ;
    endcase
    if (path_depth > 0) begin
      r.pos_x = 5'(path_stack[path_depth - 1] % SIDE);
      r.pos_y = 5'(path_stack[path_depth - 1] / SIDE);
    end
    r.advanced = flags[1];
    r.backtracked = flags[0];
    r.finished = run_done;
    r.failed = (path_depth == 0) && !run_done;
    r.depth = path_depth;
    if (req_kind_t'(it.req_type) == REQ_READ_WALL && on_grid(it.cell_x, it.cell_y)) begin
      w = maze_walls[it.cell_y * SIDE + it.cell_x];
      r.wall_left = w[0];
      r.wall_right = w[1];
      r.wall_up = w[2];
      r.wall_down = w[3];
    end
    if (req_kind_t'(it.req_type) == REQ_READ_PATH) begin
      e = it.entry_index;
      r.pos_x = '0;
      r.pos_y = '0;
      if (e < path_depth) begin
        r.pos_x = 5'(path_stack[e] % SIDE);
        r.pos_y = 5'(path_stack[e] / SIDE);
      end
    end
    return r;
  endfunction

  // result checker: every output transfer against the oldest expectation
  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_out_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_out_q.pop_front();
        check_field("pos_x", e.pos_x, out_data.pos_x);
        check_field("pos_y", e.pos_y, out_data.pos_y);
        check_field("advanced", e.advanced, out_data.advanced);
        check_field("backtracked", e.backtracked, out_data.backtracked);
        check_field("finished", e.finished, out_data.finished);
        check_field("failed", e.failed, out_data.failed);
        check_field("wall_left", e.wall_left, out_data.wall_left);
        check_field("wall_right", e.wall_right, out_data.wall_right);
        check_field("wall_up", e.wall_up, out_data.wall_up);
        check_field("wall_down", e.wall_down, out_data.wall_down);
        check_field("depth", e.depth, out_data.depth);
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      out_stall <= 1'b1;
      recv_hold_cycles = recv_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // sender: offer one request, keep valid high unless a gap is drawn
  task automatic send_req(in_item_t it);
    out_item_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predicted = predict_walk(it);
    expected_out_q.insert(expected_out_q.size(), predicted);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  // wait until every result is back, plus a margin for the block to settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[5:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_WIDTH:  grid_w_reg = val[5:0];
      CFG_GRID_HEIGHT: grid_h_reg = val[5:0];
      CFG_RUN_MODE:    mode_reg = val[0];
      CFG_START_X:     start_x_reg = val[4:0];
      CFG_START_Y:     start_y_reg = val[4:0];
      CFG_END_X:       goal_x_reg = val[4:0];
      default:         goal_y_reg = val[4:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_req(req_kind_t k);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.req_type = k;
    // path reads land mostly inside the stack
    if (k == REQ_READ_PATH && $urandom_range(3) != 0)
      it.entry_index = 10'($urandom_range(path_depth));
    return it;
  endfunction

  task automatic send_dir(dir_t d);
    in_item_t it;
    it = make_req(REQ_STEP);
    it.direction = d;
    send_req(it);
  endtask

  task automatic read_wall_at(int x, int y);
    in_item_t it;
    it = make_req(REQ_READ_WALL);
    it.cell_x = 5'(x);
    it.cell_y = 5'(y);
    send_req(it);
  endtask

  task automatic set_grid(int w, int h, int mode);
    drain();
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_RUN_MODE, mode);
  endtask

  task automatic set_route(int sx, int sy, int gx, int gy);
    drain();
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_END_X, gx);
    write_reg(CFG_END_Y, gy);
  endtask

  // directed: reset contents, every request and direction, corner cases
  task automatic test_directed();
    in_item_t it;
    read_wall_at(0, 0);
    send_dir(DIR_UP);                       // step before any start
    it = make_req(REQ_READ_PATH);
    it.entry_index = 10'd1023;
    send_req(it);
    set_grid(1, 1, 0);                      // one-cell grid finishes at once
    send_req(make_req(REQ_START));
    send_dir(DIR_RIGHT);
    set_grid(0, 63, 0);                     // sizes clamp to 1 and 32
    send_req(make_req(REQ_START));
    send_dir(DIR_UP);
    read_wall_at(31, 31);
    set_grid(2, 2, 0);
    send_req(make_req(REQ_START));
    send_dir(DIR_DOWN);
    send_dir(DIR_LEFT);
    send_dir(DIR_RIGHT);
    send_dir(DIR_UP);
    send_dir(DIR_LEFT);
    send_dir(DIR_DOWN);
    read_wall_at(1, 1);
    read_wall_at(2, 0);                     // outside the grid
    it = make_req(REQ_READ_PATH);
    it.entry_index = 10'd0;
    send_req(it);
    set_grid(2, 2, 1);
    set_route(1, 1, 1, 1);                  // start equal to goal
    send_req(make_req(REQ_START));
    set_route(31, 31, 0, 0);                // start outside the grid
    send_req(make_req(REQ_START));
    send_dir(DIR_DOWN);
    set_route(0, 0, 1, 1);
    send_req(make_req(REQ_START));
    send_dir(DIR_RIGHT);
    send_dir(DIR_UP);
  endtask

  // one random step, read, or an occasional stray request
  task automatic walk_some(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 78) send_dir(dir_t'($urandom_range(3)));
      else if (roll < 88) send_req(make_req(REQ_READ_WALL));
      else if (roll < 97) send_req(make_req(REQ_READ_PATH));
      else send_req(make_req(req_kind_t'($urandom_range(3))));
      if (!mode_reg && run_done && $urandom_range(3) == 0) break;
    end
  endtask

  // carve a maze and then search it, mostly on small grids
  task automatic test_random_mazes(int quota, int send_pct, int recv_pct);
    int w, h, goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0:       begin w = 32; h = $urandom_range(1, 32); end
        1:       begin w = $urandom_range(0, 1) ? 0 : 63; h = $urandom_range(1, 63); end
        default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
      endcase
      set_grid(w, h, 0);
      send_req(make_req(REQ_START));
      walk_some(w * h * 3 > 120 ? 120 : w * h * 3 + 4);
      drain();
      write_reg(CFG_RUN_MODE, 1);
      if ($urandom_range(7) == 0)
        set_route($urandom, $urandom, $urandom, $urandom);
      else
        set_route($urandom_range(eff_cols() - 1), $urandom_range(eff_rows() - 1),
                  $urandom_range(eff_cols() - 1), $urandom_range(eff_rows() - 1));
      send_req(make_req(REQ_START));
      walk_some($urandom_range(10, 60));
    end
  endtask

  // receiver holds off while the sender keeps offering, then a sender pause
  task automatic test_backpressure();
    set_grid(4, 4, 0);
    send_req(make_req(REQ_START));
    recv_hold_cycles = 300;
    walk_some(20);
    drain();
    walk_some(10);
  endtask

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    grid_w_reg = 6'd32;
    grid_h_reg = 6'd32;
    mode_reg = 1'b0;
    start_x_reg = '0;
    start_y_reg = '0;
    goal_x_reg = '0;
    goal_y_reg = '0;
    reset_maze();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mazes(220, 24, 47);
    test_backpressure();
    test_random_mazes(220, 47, 24);
    test_random_mazes(220, 0, 0);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
